FILE: rtl/der_cert_chain_splitter_assert.svh
// Assertion macros used by the certificate chain splitter top level.
`ifndef DER_CERT_CHAIN_SPLITTER_ASSERT_SVH
`define DER_CERT_CHAIN_SPLITTER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define DCCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dccs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DCCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dccs: next-cycle check failed");

`else

`define DCCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DCCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/dccs_pkg.sv
// Types and constants shared by the certificate chain splitter modules.
package dccs_pkg;

   // DER header bytes
   localparam logic [7:0] DER_TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] DER_LEN_LONG     = 8'h80;
   localparam logic [6:0] DER_LEN_MASK     = 7'h7F;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ENTRIES       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CERT_BYTES    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAIN_BYTE_BUDGET = 2'd2;

   localparam logic [7:0]  RST_MAX_ENTRIES       = 8'd8;
   localparam logic [15:0] RST_MAX_CERT_BYTES    = 16'd2048;
   localparam logic [15:0] RST_CHAIN_BYTE_BUDGET = 16'd8192;

   // Result kinds
   localparam logic RES_CERT = 1'b0;
   localparam logic RES_DONE = 1'b1;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  max_entries;
      logic [15:0] max_cert_bytes;
      logic [15:0] chain_byte_budget;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  cert_index;
      logic [15:0] cert_offset;
      logic [15:0] cert_length;
      logic [7:0]  cert_count;
      logic        last_of_run;
   } res_type;

   // Up to two results from one byte; first goes out before second.
   typedef struct packed {
      logic [1:0] count;
      res_type    first;
      res_type    second;
   } push_type;

   typedef struct packed {
      logic [FIFO_LVL_W-1:0] level;
      logic                  room_two;
   } fifo_status_type;

endpackage

FILE: rtl/dccs_csr_regs.sv
// Configuration registers of the certificate chain splitter.
module dccs_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_valid,
   input  logic [dccs_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [15:0]                        wr_data,
   output dccs_pkg::cfg_type                  cfg
);
   import dccs_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_entries       <= RST_MAX_ENTRIES;
         cfg_ff.max_cert_bytes    <= RST_MAX_CERT_BYTES;
         cfg_ff.chain_byte_budget <= RST_CHAIN_BYTE_BUDGET;
      end else if (wr_valid) begin
         case (wr_index)
            CSR_MAX_ENTRIES:       cfg_ff.max_entries       <= wr_data[7:0];
            CSR_MAX_CERT_BYTES:    cfg_ff.max_cert_bytes    <= wr_data;
            CSR_CHAIN_BYTE_BUDGET: cfg_ff.chain_byte_budget <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/dccs_walker.sv
// Per-byte DER header walk: parse tag and length, judge, skip body.
module dccs_walker #(
   parameter int MAX_LENGTH_BYTES = 4,
   parameter int OFFSET_BITS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  logic [7:0]         data_byte,
   input  logic               first_byte,
   input  logic [15:0]        blob_length,
   input  dccs_pkg::cfg_type  cfg,
   output dccs_pkg::push_type push
);
   import dccs_pkg::*;

   localparam int AW  = 8 * MAX_LENGTH_BYTES;
   localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int CW  = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;
   localparam logic [6:0] MAX_LEN_W = 7'(MAX_LENGTH_BYTES);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TAG  = 3'd1;
   localparam logic [2:0] PH_LEN1 = 3'd2;
   localparam logic [2:0] PH_LENX = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   logic [2:0]             phase_ff, phase_in, ph_e;
   logic [15:0]            blob_total_ff, blob_total_in, total_e;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, pos_e;
   logic [OFFSET_BITS-1:0] cert_start_ff, cert_start_in, cs_e;
   logic [LBW-1:0]         len_left_ff, len_left_in, left_e;
   logic [2:0]             header_size_ff, header_size_in, hs_e;
   logic [AW-1:0]          len_acc_ff, len_acc_in, acc_e;
   logic [15:0]            body_left_ff, body_left_in, body_e;
   logic [7:0]             count_ff, count_in, cnt_e, cnt_inc;

   logic           judge, fin, emit_ref, body_hi;
   logic [6:0]     len_w;
   logic [15:0]    body16;
   logic [CW-1:0]  room, clen, cert_end;
   res_type        ref_res, fin_res;

   always_comb begin
      // A first byte restarts the walk before it is parsed.
      if (first_byte) begin
         ph_e    = PH_TAG;
         total_e = blob_length;
         pos_e   = '0;
         cs_e    = '0;
         left_e  = '0;
         hs_e    = '0;
         acc_e   = '0;
         body_e  = '0;
         cnt_e   = '0;
      end else begin
         ph_e    = phase_ff;
         total_e = blob_total_ff;
         pos_e   = pos_ff;
         cs_e    = cert_start_ff;
         left_e  = len_left_ff;
         hs_e    = header_size_ff;
         acc_e   = len_acc_ff;
         body_e  = body_left_ff;
         cnt_e   = count_ff;
      end

      phase_in       = ph_e;
      blob_total_in  = total_e;
      pos_in         = pos_e;
      cert_start_in  = cs_e;
      len_left_in    = left_e;
      header_size_in = hs_e;
      len_acc_in     = acc_e;
      body_left_in   = body_e;
      count_in       = cnt_e;

      judge    = 1'b0;
      fin      = 1'b0;
      emit_ref = 1'b0;
      len_w    = data_byte[6:0] & DER_LEN_MASK;

      case (ph_e)
         PH_TAG: begin
            cert_start_in = pos_e;
            if (cnt_e >= cfg.max_entries ||
                CW'(total_e) < CW'(pos_e) + CW'(2) ||
                data_byte != DER_TAG_SEQUENCE) begin
               fin = 1'b1;
            end else begin
               phase_in = PH_LEN1;
            end
         end
         PH_LEN1: begin
            if (data_byte < DER_LEN_LONG) begin
               header_size_in = 3'd2;
               len_acc_in     = AW'(data_byte);
               judge          = 1'b1;
            end else if (len_w == 7'd0 || len_w > MAX_LEN_W ||
                         CW'(total_e) < CW'(cs_e) + CW'(2) + CW'(len_w)) begin
               fin = 1'b1;
            end else begin
               header_size_in = 3'd2 + 3'(len_w);
               len_left_in    = LBW'(len_w);
               len_acc_in     = '0;
               phase_in       = PH_LENX;
            end
         end
         PH_LENX: begin
            len_acc_in  = AW'({acc_e, data_byte});
            len_left_in = left_e - LBW'(1);
            if (len_left_in == '0) begin
               judge = 1'b1;
            end
         end
         PH_BODY: begin
            body_left_in = body_e - 16'd1;
            if (body_left_in == 16'd0) begin
               phase_in = PH_TAG;
            end
         end
         default: ;
      endcase

      // Judge a complete header; room is never negative here.
      body_hi  = (len_acc_in >> 16) != '0;
      body16   = 16'(len_acc_in);
      room     = CW'(total_e) - CW'(cs_e) - CW'(header_size_in);
      clen     = CW'(header_size_in) + CW'(body16);
      cert_end = CW'(cs_e) + clen;
      cnt_inc  = cnt_e + 8'd1;

      if (judge) begin
         if (len_acc_in == '0 || body_hi || CW'(body16) > room ||
             clen > CW'(cfg.max_cert_bytes) ||
             cert_end > CW'(cfg.chain_byte_budget)) begin
            fin = 1'b1;
         end else begin
            emit_ref = 1'b1;
            count_in = cnt_inc;
            if (cnt_inc >= cfg.max_entries || cert_end == CW'(total_e)) begin
               fin = 1'b1;
            end else begin
               body_left_in = body16;
               phase_in     = PH_BODY;
            end
         end
      end

      if (fin) begin
         phase_in = PH_DONE;
      end

      if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
         pos_in = pos_e + OFFSET_BITS'(1);
      end

      ref_res.result_kind = RES_CERT;
      ref_res.cert_index  = cnt_e;
      ref_res.cert_offset = 16'(cs_e);
      ref_res.cert_length = 16'(clen);
      ref_res.cert_count  = 8'd0;
      ref_res.last_of_run = !fin;

      fin_res.result_kind = RES_DONE;
      fin_res.cert_index  = 8'd0;
      fin_res.cert_offset = 16'd0;
      fin_res.cert_length = 16'd0;
      fin_res.cert_count  = count_in;
      fin_res.last_of_run = 1'b1;

      push.count  = item_valid ? ({1'b0, emit_ref} + {1'b0, fin}) : 2'd0;
      push.first  = emit_ref ? ref_res : fin_res;
      push.second = fin_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         blob_total_ff  <= '0;
         pos_ff         <= '0;
         cert_start_ff  <= '0;
         len_left_ff    <= '0;
         header_size_ff <= '0;
         len_acc_ff     <= '0;
         body_left_ff   <= '0;
         count_ff       <= '0;
      end else if (item_valid) begin
         phase_ff       <= phase_in;
         blob_total_ff  <= blob_total_in;
         pos_ff         <= pos_in;
         cert_start_ff  <= cert_start_in;
         len_left_ff    <= len_left_in;
         header_size_ff <= header_size_in;
         len_acc_ff     <= len_acc_in;
         body_left_ff   <= body_left_in;
         count_ff       <= count_in;
      end
   end

endmodule

FILE: rtl/dccs_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one while out_ready is high.
module dccs_out_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  dccs_pkg::push_type        push,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dccs_pkg::res_type         out_res,
   output dccs_pkg::fifo_status_type status
);
   import dccs_pkg::*;

   res_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;
   logic                  pop;

   assign out_valid = level_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_res   = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign level_in  = level_ff + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);

   assign status.level    = level_ff;
   assign status.room_two = level_ff <= FIFO_LVL_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

FILE: rtl/der_cert_chain_splitter.sv
// DER certificate chain splitter top level: channels, registers, walker, queue.
//
// Usage: stream a blob of concatenated DER certificates in, one byte per req
// word. req_tuser marks the first byte of a blob; that word also carries the
// blob length. Each accepted certificate yields one rsp word (kind
// reference: index, offset, total length) as soon as its header bytes are
// in; the walk ends with one word of kind finished carrying the count. A byte
// may cause two words (reference then finished); rsp_tlast marks the last.
// A result is written into the queue as its byte is taken, behind earlier words.
// Throughput: one byte per cycle while req_tready is high; the walker does a
// full header step per byte and a four-entry result queue absorbs the two-word
// bytes. req_tready drops only while the queue holds more than two words.
// Stall: if the receiver holds rsp_tready low, the queue fills and req_tready
// falls; nothing is lost or repeated. csr writes are always taken and should
// happen only while the block is idle.
// Reset: synchronous, active high. The walk goes idle (bytes ignored until a
// first byte), the queue empties and the registers return to 8 entries,
// 2048 bytes per certificate and an 8192 byte chain budget.
`include "der_cert_chain_splitter_assert.svh"

module der_cert_chain_splitter #(
   parameter int MAX_LENGTH_BYTES = 4,
   parameter int OFFSET_BITS      = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // data_byte, blob_length
   input  logic                             req_tuser,   // first_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cert_index, cert_offset, cert_length, cert_count
   output logic [47:0]                      rsp_tdata,
   output logic                             rsp_tuser,   // result_kind
   output logic                             rsp_tlast,   // last_of_run
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dccs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data
);
   import dccs_pkg::*;

   cfg_type         cfg;
   push_type        push;
   res_type         out_res;
   fifo_status_type fifo_status;
   logic            item_valid;

   // Configuration never stalls.
   assign csr_ready = 1'b1;

   dccs_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Take a byte only when the queue can hold a reference and a finish.
   assign req_tready = fifo_status.room_two;
   assign item_valid = req_tvalid && req_tready;

   dccs_walker #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
      .OFFSET_BITS      (OFFSET_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .data_byte   (req_tdata[7:0]),
      .first_byte  (req_tuser),
      .blob_length (req_tdata[23:8]),
      .cfg         (cfg),
      .push        (push)
   );

   dccs_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res),
      .status    (fifo_status)
   );

   assign rsp_tdata = {out_res.cert_count, out_res.cert_length,
                       out_res.cert_offset, out_res.cert_index};
   assign rsp_tuser = out_res.result_kind;
   assign rsp_tlast = out_res.last_of_run;

   // A finished word always closes the run of its byte.
   `DCCS_ASSERT_IMP(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser == RES_DONE, rsp_tlast)
   // A reference that is not last is followed at once by its finished word.
   `DCCS_ASSERT_NEXT(a_ref_then_done, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser == RES_CERT && !rsp_tlast, rsp_tvalid && rsp_tuser == RES_DONE)
   // The walker only pushes when the queue has room for a pair.
   `DCCS_ASSERT_IMP(a_push_has_room, clock, reset, push.count != 2'd0, fifo_status.room_two)
   // The queue never overfills.
   `DCCS_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH))

endmodule
